FILE: src/esrt_pkg.sv
// Types and constants for the serial register transaction unit.
`timescale 1ns / 1ps

package esrt_pkg;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_START_WRITE = 2'd1,
        CMD_RX_BYTE     = 2'd2,
        CMD_TICK        = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_CSUM_ERR = 2'd1,
        STS_INVALID  = 2'd2,
        STS_TIMEOUT  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_TX_BYTE = 1'b0,
        KIND_DONE    = 1'b1
    } kind_t;

    localparam int unsigned FRAME_LEN     = 5;
    localparam int unsigned CNT_W         = $clog2(FRAME_LEN + 1);
    localparam logic [7:0]  START_MARK    = 8'h80;
    localparam logic [5:0]  DEVICE_MASK   = 6'h3F;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] INVALID_VALUE = 16'hFFFF;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [1:0]  RX_DATA_BYTES = 2'd2;

    typedef struct packed {
        command_t    command;
        logic [5:0]  device_id;
        logic [7:0]  reg_addr;
        logic [15:0] write_value;
        logic [7:0]  rx_data;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_data;
        logic        last_byte;
        status_t     status;
        logic [15:0] read_value;
    } result_t;

    // Two's complement of the byte sum, modulo 256
    function automatic logic [7:0] neg_sum(input logic [7:0] sum);
        return 8'(~sum + 8'd1);
    endfunction

endpackage

FILE: src/esc_serial_register_transaction_unit.sv
// Top level: master side of a serial register link with additive checksum.
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// in      | request   | in_valid / in_ready    | in_data  (req_t)
// out     | result    | out_valid / out_ready  | out_data (result_t)
// cfg     | write     | cfg_valid / cfg_ready  | cfg_data (timeout limit, 16 bit)
//
// Ticks, received bytes and dropped requests load no frame; one request may
// follow in every cycle while the result buffer has room (in_ready high).
// A start request loads a five-byte frame into the result buffer, which then
// drains one byte per out handshake; the next request is taken as the last
// byte leaves.
// A stall on out holds the buffer and, while it holds any result, holds off in_ready.
// Reset (rst_n low, asynchronous) gives idle, an empty buffer and a timeout
// limit of 100 ticks; cfg_ready is always high.

module esc_serial_register_transaction_unit
    import esrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,

    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // ---------------------------------------------------------------
    // Transaction state
    // ---------------------------------------------------------------
    logic [15:0] timeout_limit_reg;
    logic        busy_reg,       busy_next;
    logic [1:0]  rx_count_reg,   rx_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  rx_hi_reg,      rx_hi_next;    // first response byte
    logic [7:0]  rx_lo_reg,      rx_lo_next;    // second response byte

    // ---------------------------------------------------------------
    // Result buffer: a five-byte shift line for frames, or one
    // finished report. cnt_reg holds the results still to deliver.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    kind_t            kind_reg,   kind_next;
    status_t          status_reg, status_next;
    logic [15:0]      value_reg,  value_next;
    logic [7:0]       tx_shift_reg  [FRAME_LEN];
    logic [7:0]       tx_shift_next [FRAME_LEN];

    logic       in_fire;
    logic       out_fire;
    logic       load_frame;
    logic       load_done;
    logic [7:0] frame [FRAME_LEN];
    logic [15:0] tx_word;
    logic [7:0]  frame_sum;
    logic [7:0]  rx_csum;
    logic [15:0] rx_word;
    logic [15:0] tick_inc;
    status_t     done_status;
    logic [15:0] done_value;

    assign cfg_ready = 1'b1;

    // Room for new results once the buffer empties or its last entry leaves
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;

    // Outgoing frame
    assign tx_word   = (in_data.command == CMD_START_WRITE) ? in_data.write_value : 16'd0;
    assign frame[0]  = START_MARK | {2'b00, in_data.device_id & DEVICE_MASK};
    assign frame[1]  = in_data.reg_addr;
    assign frame[2]  = tx_word[15:8];
    assign frame[3]  = tx_word[7:0];
    assign frame_sum = frame[0] + frame[1] + frame[2] + frame[3];
    assign frame[4]  = neg_sum(frame_sum);

    // Response checks
    assign rx_word  = {rx_hi_reg, rx_lo_reg};
    assign rx_csum  = neg_sum(rx_hi_reg + rx_lo_reg);
    assign tick_inc = (tick_count_reg == TICK_MAX) ? tick_count_reg : tick_count_reg + 16'd1;

    always_comb
    begin
        busy_next       = busy_reg;
        rx_count_next   = rx_count_reg;
        tick_count_next = tick_count_reg;
        rx_hi_next      = rx_hi_reg;
        rx_lo_next      = rx_lo_reg;
        load_frame      = 1'b0;
        load_done       = 1'b0;
        done_status     = STS_OK;
        done_value      = 16'd0;

        if (in_fire)
        begin
            unique case (in_data.command) inside
                CMD_START_READ, CMD_START_WRITE:
                begin
                    if (!busy_reg)
                    begin
                        load_frame      = 1'b1;
                        busy_next       = 1'b1;
                        rx_count_next   = 2'd0;
                        tick_count_next = 16'd0;
                    end
                end
                CMD_RX_BYTE:
                begin
                    if (busy_reg)
                    begin
                        if (rx_count_reg < RX_DATA_BYTES)
                        begin
                            if (rx_count_reg[0])
                                rx_lo_next = in_data.rx_data;
                            else
                                rx_hi_next = in_data.rx_data;
                            rx_count_next = rx_count_reg + 2'd1;
                        end
                        else
                        begin
                            // Checksum byte: close the transaction
                            load_done       = 1'b1;
                            busy_next       = 1'b0;
                            rx_count_next   = 2'd0;
                            tick_count_next = 16'd0;
                            if (rx_csum != in_data.rx_data)
                                done_status = STS_CSUM_ERR;
                            else if (rx_word == INVALID_VALUE)
                                done_status = STS_INVALID;
                            else
                                done_value  = rx_word;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (busy_reg)
                    begin
                        if (tick_inc > timeout_limit_reg)
                        begin
                            load_done       = 1'b1;
                            done_status     = STS_TIMEOUT;
                            busy_next       = 1'b0;
                            rx_count_next   = 2'd0;
                            tick_count_next = 16'd0;
                        end
                        else
                            tick_count_next = tick_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result buffer next state: a load replaces whatever is leaving
    always_comb
    begin
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        value_next  = value_reg;
        for (int i = 0; i < FRAME_LEN; i++)
            tx_shift_next[i] = tx_shift_reg[i];

        if (out_fire)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < FRAME_LEN - 1; i++)
                tx_shift_next[i] = tx_shift_reg[i + 1];
            tx_shift_next[FRAME_LEN - 1] = 8'd0;
        end

        if (load_frame)
        begin
            cnt_next    = CNT_W'(FRAME_LEN);
            kind_next   = KIND_TX_BYTE;
            status_next = STS_OK;
            value_next  = 16'd0;
            for (int i = 0; i < FRAME_LEN; i++)
                tx_shift_next[i] = frame[i];
        end
        else if (load_done)
        begin
            cnt_next    = CNT_W'(1);
            kind_next   = KIND_DONE;
            status_next = done_status;
            value_next  = done_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_RESET;
            busy_reg          <= 1'b0;
            rx_count_reg      <= 2'd0;
            tick_count_reg    <= 16'd0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_limit_reg <= cfg_data;
            busy_reg       <= busy_next;
            rx_count_reg   <= rx_count_next;
            tick_count_reg <= tick_count_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rx_hi_reg  <= rx_hi_next;
        rx_lo_reg  <= rx_lo_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        for (int i = 0; i < FRAME_LEN; i++)
            tx_shift_reg[i] <= tx_shift_next[i];
    end

    // Fields not used by a result kind read as zero
    always_comb
    begin
        out_data.kind       = kind_reg;
        out_data.tx_data    = (kind_reg == KIND_TX_BYTE) ? tx_shift_reg[0] : 8'd0;
        out_data.last_byte  = (kind_reg == KIND_TX_BYTE) && (cnt_reg == CNT_W'(1));
        out_data.status     = (kind_reg == KIND_DONE) ? status_reg : STS_OK;
        out_data.read_value = (kind_reg == KIND_DONE) ? value_reg : 16'd0;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (cnt_reg <= CNT_W'(1)))
        else $error("request taken while result buffer still full");

    a_start_loads_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !busy_reg && ((in_data.command == CMD_START_READ) ||
                                  (in_data.command == CMD_START_WRITE)))
        |=> (busy_reg && (cnt_reg == CNT_W'(FRAME_LEN)) && (kind_reg == KIND_TX_BYTE)))
        else $error("start request did not load a full frame");

    a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (out_valid && (kind_reg == KIND_DONE)))
        else $error("transaction ended without a finished report");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> ((rx_count_reg == 2'd0) && (tick_count_reg == 16'd0)))
        else $error("idle with response count or tick count set");

    a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= RX_DATA_BYTES)
        else $error("response byte count out of range");

endmodule
